// File: src/utf8_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// utf8_stream_decoder_defines
// Assertion macros shared by u8sd_decode and u8sd_rqueue.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define U8SD_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define U8SD_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

    localparam int unsigned CP_W            = 31;
    localparam int unsigned LEFT_W          = 3;
    localparam int unsigned U8SD_QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 31'h0000_fffd;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
    } t_result;

    // Results produced by one request: count 0..2, first in res0.
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

`default_nettype wire

// File: src/u8sd_decode.sv
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and per-byte decode; emits up to two results per request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module u8sd_decode
    import u8sd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output t_dec_out        o_dec
);

    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;
    logic [CP_W-1:0]   r_partial;
    logic [CP_W-1:0]   n_partial;
    logic [CP_W-1:0]   shifted;
    t_dec_out          dec;

    assign shifted = {r_partial[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_left    = r_left;
        n_partial = r_partial;
        dec       = '0;
        if (r_left != '0) begin
            if (i_byte == 8'd0) begin
                n_left    = '0;
                n_partial = '0;
                dec.num   = 2'd2;
                dec.res0  = '{code_point: REPLACEMENT_CP, last: 1'b0};
                dec.res1  = '{code_point: '0, last: 1'b1};
            end else begin
                n_left = r_left - 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    n_partial = '0;
                    dec.num   = 2'd1;
                    dec.res0  = '{code_point: shifted, last: 1'b1};
                end else begin
                    n_partial = shifted;
                end
            end
        end else begin
            case (i_byte) inside
                [8'd0:8'd127]: begin
                    dec.num  = 2'd1;
                    dec.res0 = '{code_point: CP_W'(i_byte), last: 1'b1};
                end
                [8'd192:8'd223]: begin
                    n_partial = CP_W'(i_byte[4:0]);
                    n_left    = LEFT_W'(1);
                end
                [8'd224:8'd239]: begin
                    n_partial = CP_W'(i_byte[3:0]);
                    n_left    = LEFT_W'(2);
                end
                [8'd240:8'd247]: begin
                    n_partial = CP_W'(i_byte[2:0]);
                    n_left    = LEFT_W'(3);
                end
                [8'd248:8'd251]: begin
                    n_partial = CP_W'(i_byte[1:0]);
                    n_left    = LEFT_W'(4);
                end
                [8'd252:8'd253]: begin
                    n_partial = CP_W'(i_byte[0]);
                    n_left    = LEFT_W'(5);
                end
                default: begin
                    dec.num  = 2'd1;
                    dec.res0 = '{code_point: REPLACEMENT_CP, last: 1'b1};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_partial <= '0;
        end else if (i_fire) begin
            r_left    <= n_left;
            r_partial <= n_partial;
        end
    end

    always_comb begin
        o_dec     = dec;
        o_dec.num = i_fire ? dec.num : 2'd0;
    end

    `U8SD_CHECK(a_two_only_on_zero, i_clk, i_rst_n, (o_dec.num == 2'd2) |-> (r_left != '0 && i_byte == 8'd0), "two results without a zero byte inside a sequence")
    `U8SD_CHECK(a_close_clears, i_clk, i_rst_n, (i_fire && r_left == LEFT_W'(1) && i_byte != 8'd0) |=> (r_left == '0 && r_partial == '0), "sequence end did not clear state")
    `U8SD_CHECK(a_left_range, i_clk, i_rst_n, r_left <= LEFT_W'(5), "bytes left out of range")

endmodule

`default_nettype wire

// File: src/u8sd_rqueue.sv
// ----------------------------------------------------------------------------
// u8sd_rqueue
// Small result queue; takes up to two results per cycle, releases one when the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module u8sd_rqueue
    import u8sd_pkg::*;
#(
    parameter int unsigned Depth = U8SD_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_dec_out         i_dec,
    output logic             o_space,
    output logic [CP_W-1:0]  o_code_point,
    output logic             o_last,
    output logic             o_valid,
    input  wire logic        i_ready
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    function automatic logic [PtrW-1:0] f_next(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    t_result           r_slot [Depth];
    logic [PtrW-1:0]   r_head;
    logic [PtrW-1:0]   r_tail;
    logic [CntW-1:0]   r_count;
    logic [PtrW-1:0]   n_head;
    logic [PtrW-1:0]   n_tail;
    logic [CntW-1:0]   n_count;
    logic [PtrW-1:0]   wr1;
    logic              pop;

    assign wr1   = f_next(r_tail);
    assign pop   = o_valid && i_ready;

    assign o_valid      = (r_count != '0);
    assign o_space      = (r_count <= CntW'(Depth - 2));
    assign o_code_point = r_slot[r_head].code_point;
    assign o_last       = r_slot[r_head].last;

    always_comb begin
        n_head  = pop ? f_next(r_head) : r_head;
        n_count = r_count + CntW'(i_dec.num) - CntW'(pop);
        case (i_dec.num)
            2'd1:    n_tail = wr1;
            2'd2:    n_tail = f_next(wr1);
            default: n_tail = r_tail;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dec.num != 2'd0) begin
            r_slot[r_tail] <= i_dec.res0;
        end
        if (i_dec.num == 2'd2) begin
            r_slot[wr1] <= i_dec.res1;
        end
    end

    `U8SD_CHECK(a_no_overflow, i_clk, i_rst_n, (i_dec.num != 2'd0) |-> ((CntW + 1)'(r_count) + (CntW + 1)'(i_dec.num) <= (CntW + 1)'(Depth)), "result queue overflow")
    `U8SD_CHECK(a_pop_count, i_clk, i_rst_n, (pop && i_dec.num == 2'd0) |=> (r_count == $past(r_count) - 1'b1), "count did not drop on release")
    `U8SD_CHECK(a_count_bound, i_clk, i_rst_n, r_count <= CntW'(Depth), "count beyond depth")

endmodule

`default_nettype wire

// File: src/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial decoder for the six-byte form of UTF-8.
// ----------------------------------------------------------------------------
// One byte request is taken per clock while the result queue holds at most
// QueueDepth-2 entries; a result is registered in the result queue when the
// byte that completes it is taken. Each byte yields zero, one or two results,
// and results leave one per cycle while the output is ready, so the sustained
// rate is one byte per cycle except that a zero byte inside an open sequence
// (U+FFFD then U+0000) yields two results. The result queue depth sets how
// much output stall is absorbed before input ready drops.
`default_nettype none

module utf8_stream_decoder
    import u8sd_pkg::*;
#(
    parameter int unsigned QueueDepth = U8SD_QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_in_byte,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [CP_W-1:0]      o_code_point,
    output logic                 o_last
);

    t_dec_out dec;
    logic     fire;

    assign fire = i_valid && o_ready;

    u8sd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_in_byte),
        .o_dec   (dec)
    );

    u8sd_rqueue #(
        .Depth (QueueDepth)
    ) u_rqueue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dec        (dec),
        .o_space      (o_ready),
        .o_code_point (o_code_point),
        .o_last       (o_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready)
    );

endmodule

`default_nettype wire

// File: sim/utf8_decode_checker.sv
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches both channels of the UTF-8 stream decoder. Each accepted byte is
// run through a local decoder that produces the expected code points. Each
// accepted code point is compared field by field with the oldest one still
// expected. The failure count and the number of outstanding code points go
// to the testbench top.
// ----------------------------------------------------------------------------
module utf8_decode_checker
    import u8sd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_byte_valid,
    input  logic            i_byte_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_cp_valid,
    input  logic            i_cp_ready,
    input  logic [CP_W-1:0] i_code_point,
    input  logic            i_last,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_result           expected_cps[$];
    logic [LEFT_W-1:0] seq_left;
    logic [CP_W-1:0]   seq_value;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        seq_left     = '0;
        seq_value    = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic push_cp(input logic [CP_W-1:0] cp, input logic last);
        t_result r;
        r.code_point = cp;
        r.last       = last;
        expected_cps.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        if (seq_left != '0) begin
            if (b == 8'h00) begin
                // zero inside a sequence aborts it: U+FFFD, then U+0000
                push_cp(REPLACEMENT_CP, 1'b0);
                push_cp('0, 1'b1);
                seq_left  = '0;
                seq_value = '0;
            end else begin
                // prefix bits of the follow-on byte are dropped, not checked
                seq_value = {seq_value[CP_W-7:0], b[5:0]};
                seq_left  = seq_left - 1'b1;
                if (seq_left == '0) begin
                    push_cp(seq_value, 1'b1);
                    seq_value = '0;
                end
            end
        end else if (!b[7]) begin
            push_cp(CP_W'(b), 1'b1);
        end else if (b[7:5] == 3'b110) begin
            seq_value = CP_W'(b[4:0]);
            seq_left  = 3'd1;
        end else if (b[7:4] == 4'b1110) begin
            seq_value = CP_W'(b[3:0]);
            seq_left  = 3'd2;
        end else if (b[7:3] == 5'b11110) begin
            seq_value = CP_W'(b[2:0]);
            seq_left  = 3'd3;
        end else if (b[7:2] == 6'b111110) begin
            seq_value = CP_W'(b[1:0]);
            seq_left  = 3'd4;
        end else if (b[7:1] == 7'b1111110) begin
            seq_value = CP_W'(b[0]);
            seq_left  = 3'd5;
        end else begin
            // stray continuation byte or 0xfe/0xff
            push_cp(REPLACEMENT_CP, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            seq_left  = '0;
            seq_value = '0;
            expected_cps.delete();
        end else begin
            if (i_cp_valid && i_cp_ready) begin
                if (expected_cps.size() == 0) begin
                    report_mismatch($sformatf("unexpected code point %0h last %0b",
                                              i_code_point, i_last));
                end else begin
                    want = expected_cps.pop_front();
                    if (i_code_point !== want.code_point)
                        report_mismatch($sformatf("code_point got %0h want %0h",
                                                  i_code_point, want.code_point));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b (cp %0h)",
                                                  i_last, want.last, want.code_point));
                end
            end
            if (i_byte_valid && i_byte_ready)
                decode_byte(i_byte);
        end
        o_pending = expected_cps.size();
    end

endmodule

// File: sim/tb_utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Byte stream stimulus for the UTF-8 stream decoder. A directed set of
// boundary bytes and sequences comes first. Random traffic follows: mostly
// well-formed sequences, plus aborted and unchecked sequences and stray
// bytes. Both sides idle at random. At times the output is held off long
// enough to back up the input, and at times the input drains completely.
// Checking is done in utf8_decode_checker.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
    import u8sd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int DIRECTED_N  = 26;
    localparam int RANDOM_N    = 1100;
    localparam int LONG_HOLD   = 200;
    localparam int TAIL_CYCLES = 20;
    localparam int LIMIT       = 200000;

    logic            clk;
    logic            rst_n;
    logic            byte_valid;
    logic            byte_ready;
    logic [7:0]      byte_data;
    logic            cp_valid;
    logic            cp_ready;
    logic [CP_W-1:0] code_point;
    logic            cp_last;

    int fail_count;
    int pending;
    int items_sent;
    int cycle_count;
    bit no_idle;
    bit stall_burst_req;
    bit mid_pause_done;

    logic [7:0] directed_bytes [DIRECTED_N] = '{
        8'h00, 8'h7f, 8'h80, 8'hbf, 8'hfe, 8'hff,
        8'hc0, 8'h80,
        8'hdf, 8'hff,
        8'hef, 8'h41, 8'hbf,
        8'hf8, 8'h80, 8'h00,
        8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
        8'hf7, 8'hbf, 8'hbf, 8'hbf
    };

    utf8_stream_decoder DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (byte_valid),
        .o_ready      (byte_ready),
        .i_in_byte    (byte_data),
        .o_valid      (cp_valid),
        .i_ready      (cp_ready),
        .o_code_point (code_point),
        .o_last       (cp_last)
    );

    utf8_decode_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte_valid (byte_valid),
        .i_byte_ready (byte_ready),
        .i_byte       (byte_data),
        .i_cp_valid   (cp_valid),
        .i_cp_ready   (cp_ready),
        .i_code_point (code_point),
        .i_last       (cp_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one byte request; returns at the edge where it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_data  <= b;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic send_random_sequence();
        int         kind;
        int         len;
        logic [7:0] lead;
        logic [7:0] follow;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            send_byte(8'($urandom_range(0, 127)));
        end else if (kind < 82) begin
            len  = $urandom_range(1, 5);
            lead = 8'($urandom);
            case (len)
                1: lead[7:5] = 3'b110;
                2: lead[7:4] = 4'b1110;
                3: lead[7:3] = 5'b11110;
                4: lead[7:2] = 6'b111110;
                default: lead[7:1] = 7'b1111110;
            endcase
            send_byte(lead);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_byte(8'h00);
                    break;
                end
                follow = {2'b10, 6'($urandom)};
                if ($urandom_range(0, 9) == 0)
                    follow = 8'($urandom);
                send_byte(follow);
            end
        end else if (kind < 90) begin
            if ($urandom_range(0, 3) == 0)
                send_byte(8'($urandom_range(254, 255)));
            else
                send_byte(8'($urandom_range(128, 191)));
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    // result side: random hold-off per result, long hold on request
    initial begin
        int hold;
        wait (rst_n === 1'b1);
        forever begin
            if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 4);
            end
            repeat (hold) begin
                @(negedge clk);
                cp_ready <= 1'b0;
            end
            @(negedge clk);
            cp_ready <= 1'b1;
            @(posedge clk);
            while (!cp_valid) @(posedge clk);
        end
    end

    initial begin
        rst_n           = 1'b0;
        byte_valid      = 1'b0;
        byte_data       = '0;
        cp_ready        = 1'b0;
        no_idle         = 1'b0;
        stall_burst_req = 1'b0;
        mid_pause_done  = 1'b0;
        items_sent      = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        wait_drained();
        stall_burst_req = 1'b1;

        while (items_sent < DIRECTED_N + RANDOM_N) begin
            no_idle = (items_sent >= DIRECTED_N + 300) && (items_sent < DIRECTED_N + 450);
            if (!mid_pause_done && items_sent >= DIRECTED_N + 700) begin
                wait_drained();
                stall_burst_req = 1'b1;
                mid_pause_done  = 1'b1;
            end
            send_random_sequence();
        end

        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: utf8_stream_decoder.f
+incdir+src
src/u8sd_pkg.sv
src/u8sd_decode.sv
src/u8sd_rqueue.sv
src/utf8_stream_decoder.sv
sim/utf8_decode_checker.sv
sim/tb_utf8_stream_decoder.sv
